// ===== rtl/fms_pkg.sv =====
`default_nettype none

package fms_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_ENC_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_OC_LIMIT    = 2'd1;
    localparam logic [1:0] REG_PWR_LIMIT   = 2'd2;
    localparam logic [1:0] REG_REC_DELAY   = 2'd3;

    localparam logic [31:0] ENC_TIMEOUT_RST = 32'd100;
    localparam logic [11:0] OC_LIMIT_RST    = 12'd3000;
    localparam logic [15:0] PWR_LIMIT_RST   = 16'd10000;
    localparam logic [31:0] REC_DELAY_RST   = 32'd1000;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ENCODER = 3'd1;
    localparam logic [2:0] CMD_CURRENT = 3'd2;
    localparam logic [2:0] CMD_POWER   = 3'd3;
    localparam logic [2:0] CMD_RECOVER = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    localparam logic [7:0] F_ENC_STALE   = 8'h01;
    localparam logic [7:0] F_ENC_INVALID = 8'h02;
    localparam logic [7:0] F_OC_LEFT     = 8'h04;
    localparam logic [7:0] F_OC_RIGHT    = 8'h08;
    localparam logic [7:0] F_POWER_LOW   = 8'h10;

    localparam logic [1:0] ENC_DEBOUNCE = 2'd2;
    localparam logic [1:0] OC_DEBOUNCE  = 2'd3;
    localparam logic [2:0] PWR_DEBOUNCE = 3'd4;

    localparam int EV_SAFE  = 0;
    localparam int EV_ENC   = 1;
    localparam int EV_OC    = 2;
    localparam int EV_POWER = 3;
    localparam int EV_RECOV = 4;
    localparam int EV_KICK  = 5;
    localparam int EV_COUNT = 6;

    typedef struct packed {
        logic [31:0] encoder_timeout_ms;
        logic [11:0] overcurrent_limit;
        logic [15:0] power_low_limit_mv;
        logic [31:0] recovery_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  command;
        logic        encoder_valid;
        logic [31:0] now_ms;
        logic [11:0] right_current;
        logic [11:0] left_current;
        logic [15:0] supply_voltage;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  fault_flags;
        logic [7:0]  latched_flags;
        logic        safe_active;
        logic [31:0] safe_entries;
        logic [31:0] encoder_timeout_count;
        logic [31:0] overcurrent_count;
        logic [31:0] power_low_count;
        logic [31:0] recovery_count;
        logic [31:0] kick_count;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/fms_cfg_regs.sv =====
`default_nettype none

module fms_cfg_regs
    import fms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.encoder_timeout_ms <= ENC_TIMEOUT_RST;
            cfg_reg.overcurrent_limit  <= OC_LIMIT_RST;
            cfg_reg.power_low_limit_mv <= PWR_LIMIT_RST;
            cfg_reg.recovery_delay_ms  <= REC_DELAY_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ENC_TIMEOUT: cfg_reg.encoder_timeout_ms <= pwdata;
                REG_OC_LIMIT:    cfg_reg.overcurrent_limit  <= pwdata[11:0];
                REG_PWR_LIMIT:   cfg_reg.power_low_limit_mv <= pwdata[15:0];
                REG_REC_DELAY:   cfg_reg.recovery_delay_ms  <= pwdata;
                default:         cfg_reg.recovery_delay_ms  <= cfg_reg.recovery_delay_ms;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ENC_TIMEOUT: prdata = cfg_reg.encoder_timeout_ms;
            REG_OC_LIMIT:    prdata = {20'd0, cfg_reg.overcurrent_limit};
            REG_PWR_LIMIT:   prdata = {16'd0, cfg_reg.power_low_limit_mv};
            REG_REC_DELAY:   prdata = cfg_reg.recovery_delay_ms;
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/fms_engine.sv =====
`default_nettype none

module fms_engine
    import fms_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic fire,
    input  wire cmd_t item,
    input  wire cfg_t cfg,
    output status_t   result
);

    logic [7:0]  act_reg,   act_next;
    logic [7:0]  latch_reg, latch_next;
    logic [1:0]  enc_cnt_reg,   enc_cnt_next;
    logic [1:0]  left_cnt_reg,  left_cnt_next;
    logic [1:0]  right_cnt_reg, right_cnt_next;
    logic [2:0]  sup_cnt_reg,   sup_cnt_next;
    logic        safe_reg,  safe_next;
    logic [31:0] entry_reg, entry_next;
    logic [31:0] last_enc_reg, last_enc_next;
    logic [31:0] ev_reg  [EV_COUNT];
    logic [31:0] ev_next [EV_COUNT];
    logic [1:0]  ev_inc  [EV_COUNT];
    logic [31:0] enc_age;
    logic [31:0] safe_age;

    assign enc_age  = item.now_ms - last_enc_reg;
    assign safe_age = item.now_ms - entry_reg;

    always_comb
    begin
        act_next       = act_reg;
        latch_next     = latch_reg;
        enc_cnt_next   = enc_cnt_reg;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        sup_cnt_next   = sup_cnt_reg;
        safe_next      = safe_reg;
        entry_next     = entry_reg;
        last_enc_next  = last_enc_reg;
        for (int i = 0; i < EV_COUNT; i++)
        begin
            ev_inc[i] = 2'd0;
        end

        unique case (item.command)
            CMD_TICK:
            begin
                ev_inc[EV_KICK] = 2'd1;
            end
            CMD_ENCODER:
            begin
                if (item.encoder_valid)
                begin
                    last_enc_next = item.now_ms;
                    enc_cnt_next  = 2'd0;
                    if (!safe_next)
                    begin
                        act_next = act_next & ~(F_ENC_STALE | F_ENC_INVALID);
                    end
                end
                else if (enc_age > cfg.encoder_timeout_ms && enc_cnt_next < ENC_DEBOUNCE)
                begin
                    enc_cnt_next = enc_cnt_next + 2'd1;
                    if (enc_cnt_next == ENC_DEBOUNCE)
                    begin
                        act_next       = act_next | F_ENC_STALE | F_ENC_INVALID;
                        latch_next     = latch_next | F_ENC_INVALID;
                        ev_inc[EV_ENC] = 2'd1;
                        if (!safe_next)
                        begin
                            safe_next       = 1'b1;
                            entry_next      = item.now_ms;
                            ev_inc[EV_SAFE] = 2'd1;
                        end
                    end
                end
            end
            CMD_CURRENT:
            begin
                // The left channel is handled first; its safe-state entry is seen by the right.
                if (item.left_current > cfg.overcurrent_limit)
                begin
                    if (left_cnt_next < OC_DEBOUNCE)
                    begin
                        left_cnt_next = left_cnt_next + 2'd1;
                        if (left_cnt_next == OC_DEBOUNCE)
                        begin
                            act_next      = act_next | F_OC_LEFT;
                            latch_next    = latch_next | F_OC_LEFT;
                            ev_inc[EV_OC] = ev_inc[EV_OC] + 2'd1;
                            if (!safe_next)
                            begin
                                safe_next       = 1'b1;
                                entry_next      = item.now_ms;
                                ev_inc[EV_SAFE] = 2'd1;
                            end
                        end
                    end
                end
                else
                begin
                    left_cnt_next = 2'd0;
                    if (!safe_next)
                    begin
                        act_next = act_next & ~F_OC_LEFT;
                    end
                end
                if (item.right_current > cfg.overcurrent_limit)
                begin
                    if (right_cnt_next < OC_DEBOUNCE)
                    begin
                        right_cnt_next = right_cnt_next + 2'd1;
                        if (right_cnt_next == OC_DEBOUNCE)
                        begin
                            act_next      = act_next | F_OC_RIGHT;
                            latch_next    = latch_next | F_OC_RIGHT;
                            ev_inc[EV_OC] = ev_inc[EV_OC] + 2'd1;
                            if (!safe_next)
                            begin
                                safe_next       = 1'b1;
                                entry_next      = item.now_ms;
                                ev_inc[EV_SAFE] = 2'd1;
                            end
                        end
                    end
                end
                else
                begin
                    right_cnt_next = 2'd0;
                    if (!safe_next)
                    begin
                        act_next = act_next & ~F_OC_RIGHT;
                    end
                end
            end
            CMD_POWER:
            begin
                if (item.supply_voltage < cfg.power_low_limit_mv)
                begin
                    if (sup_cnt_next < PWR_DEBOUNCE)
                    begin
                        sup_cnt_next = sup_cnt_next + 3'd1;
                    end
                    if (sup_cnt_next == PWR_DEBOUNCE)
                    begin
                        act_next         = act_next | F_POWER_LOW;
                        latch_next       = latch_next | F_POWER_LOW;
                        ev_inc[EV_POWER] = 2'd1;
                        if (!safe_next)
                        begin
                            safe_next       = 1'b1;
                            entry_next      = item.now_ms;
                            ev_inc[EV_SAFE] = 2'd1;
                        end
                    end
                end
                else
                begin
                    sup_cnt_next = 3'd0;
                    if (!safe_next)
                    begin
                        act_next = act_next & ~F_POWER_LOW;
                    end
                end
            end
            CMD_RECOVER:
            begin
                if (safe_reg && act_reg == 8'd0 && safe_age > cfg.recovery_delay_ms)
                begin
                    safe_next        = 1'b0;
                    ev_inc[EV_RECOV] = 2'd1;
                    last_enc_next    = item.now_ms;
                end
            end
            CMD_CLEAR:
            begin
                act_next       = 8'd0;
                latch_next     = 8'd0;
                enc_cnt_next   = 2'd0;
                left_cnt_next  = 2'd0;
                right_cnt_next = 2'd0;
                sup_cnt_next   = 3'd0;
                safe_next      = 1'b0;
            end
            default:
            begin
                safe_next = safe_reg;
            end
        endcase

        for (int i = 0; i < EV_COUNT; i++)
        begin
            ev_next[i] = ev_reg[i] + {30'd0, ev_inc[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= '0;
            latch_reg     <= '0;
            enc_cnt_reg   <= '0;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            sup_cnt_reg   <= '0;
            safe_reg      <= 1'b0;
            entry_reg     <= '0;
            last_enc_reg  <= '0;
            for (int i = 0; i < EV_COUNT; i++)
            begin
                ev_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            act_reg       <= act_next;
            latch_reg     <= latch_next;
            enc_cnt_reg   <= enc_cnt_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            sup_cnt_reg   <= sup_cnt_next;
            safe_reg      <= safe_next;
            entry_reg     <= entry_next;
            last_enc_reg  <= last_enc_next;
            for (int i = 0; i < EV_COUNT; i++)
            begin
                ev_reg[i] <= ev_next[i];
            end
        end
    end

    always_comb
    begin
        result.fault_flags           = act_next;
        result.latched_flags         = latch_next;
        result.safe_active           = safe_next;
        result.safe_entries          = ev_next[EV_SAFE];
        result.encoder_timeout_count = ev_next[EV_ENC];
        result.overcurrent_count     = ev_next[EV_OC];
        result.power_low_count       = ev_next[EV_POWER];
        result.recovery_count        = ev_next[EV_RECOV];
        result.kick_count            = ev_next[EV_KICK];
    end

endmodule

`default_nettype wire

// ===== rtl/fault_monitor_safe_state.sv =====
// Safety monitor for a motor controller. Each command transaction (tick, encoder check,
// current check, supply check, recovery attempt, clear or reserved code) yields exactly one
// status transaction with the fault flags, the safe-state bit and the event counters as they
// stand after that command. One command is taken every clock cycle while the output is not
// stalled; its status passes through the command register and then the status register. The
// rate rests on the fault state being computed combinationally from the registered command.
// The user must write the limits through the APB port (pready is always high) only while no
// command is in flight; the block itself does not enforce this.
`default_nettype none

module fault_monitor_safe_state
    import fms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire cmd_t                  cmd,
    output logic                       status_valid,
    input  wire logic                  status_stall,
    output status_t                    status
);

    cfg_t    cfg;
    cmd_t    cmd_reg;
    logic    cmd_valid_reg, cmd_valid_next;
    status_t status_reg;
    status_t result;
    logic    status_valid_reg, status_valid_next;
    logic    fire;
    logic    accept;

    fms_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fms_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (cmd_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign fire      = cmd_valid_reg && (!status_valid_reg || !status_stall);
    assign cmd_stall = cmd_valid_reg && !fire;
    assign accept    = cmd_valid && !cmd_stall;

    assign status_valid = status_valid_reg;
    assign status       = status_reg;

    always_comb
    begin
        priority if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (fire)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end

        priority if (fire)
        begin
            status_valid_next = 1'b1;
        end
        else if (!status_stall)
        begin
            status_valid_next = 1'b0;
        end
        else
        begin
            status_valid_next = status_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg    <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg    <= cmd_valid_next;
            status_valid_reg <= status_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (fire)
        begin
            status_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // A command is held back only while an earlier one waits in the command register.
    assert_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> cmd_valid_reg)
        else $error("command stalled with an empty command register");

    // A waiting command moves into an empty status register at once.
    assert_drain_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && !status_valid_reg) |=> status_valid_reg)
        else $error("command not processed into an empty status register");

    // Active faults can only exist while the block is in safe state.
    assert_faults_imply_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (status_valid && status.fault_flags != 8'd0) |-> status.safe_active)
        else $error("active fault reported outside safe state");

    // Every active fault other than encoder stale is also latched.
    assert_active_latched: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> ((status.fault_flags[4:1] & ~status.latched_flags[4:1]) == 4'd0))
        else $error("active fault without its latched bit");

    // Undefined flag bits stay clear.
    assert_unused_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> (status.fault_flags[7:5] == 3'd0 && status.latched_flags[7:5] == 3'd0))
        else $error("unused fault flag bit set");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fms_pkg::*;

    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;
    localparam int IDLE_PERCENT = 17;
    localparam int RANDOM_ITEMS = 1900;
    localparam int PHASES = 5;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_t                  cmd = '0;
    logic                  status_valid;
    logic                  status_stall = 1'b0;
    status_t               status;

    // Tracks the monitor's fault state and counters and holds the status
    // transactions still owed by the block, oldest first.
    class safety_status_model;
        bit [31:0] encoder_timeout;
        bit [11:0] current_limit;
        bit [15:0] supply_limit;
        bit [31:0] recovery_delay;
        bit [7:0]  active;
        bit [7:0]  latched;
        bit [1:0]  encoder_bad;
        bit [1:0]  left_over;
        bit [1:0]  right_over;
        bit [2:0]  supply_low;
        bit        in_safe;
        bit [31:0] safe_since;
        bit [31:0] encoder_seen;
        bit [31:0] events [EV_COUNT];
        status_t   expected_status [$];
        int        mismatches;

        function new();
            encoder_timeout = ENC_TIMEOUT_RST;
            current_limit = OC_LIMIT_RST;
            supply_limit = PWR_LIMIT_RST;
            recovery_delay = REC_DELAY_RST;
            mismatches = 0;
        endfunction

        function void set_limit(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_ENC_TIMEOUT: encoder_timeout = value;
                REG_OC_LIMIT:    current_limit = value[11:0];
                REG_PWR_LIMIT:   supply_limit = value[15:0];
                REG_REC_DELAY:   recovery_delay = value;
                default: ;
            endcase
        endfunction

        function void enter_safe(bit [31:0] now);
            if (!in_safe)
            begin
                in_safe = 1'b1;
                safe_since = now;
                events[EV_SAFE] += 1;
            end
        endfunction

        function bit [1:0] check_channel(bit [11:0] reading, bit [1:0] count,
                                         bit [7:0] mask, bit [31:0] now);
            bit [1:0] next;
            next = count;
            if (reading > current_limit)
            begin
                if (count < OC_DEBOUNCE)
                begin
                    next = count + 2'd1;
                    if (next == OC_DEBOUNCE)
                    begin
                        active |= mask;
                        latched |= mask;
                        events[EV_OC] += 1;
                        enter_safe(now);
                    end
                end
            end
            else
            begin
                next = '0;
                if (!in_safe)
                    active &= ~mask;
            end
            return next;
        endfunction

        function void note_command(cmd_t c);
            bit [31:0] since_encoder;
            bit [31:0] since_entry;
            status_t   s;
            since_encoder = c.now_ms - encoder_seen;
            since_entry = c.now_ms - safe_since;
            case (c.command)
                CMD_TICK: events[EV_KICK] += 1;
                CMD_ENCODER:
                    if (c.encoder_valid)
                    begin
                        encoder_seen = c.now_ms;
                        encoder_bad = '0;
                        if (!in_safe)
                            active &= ~(F_ENC_STALE | F_ENC_INVALID);
                    end
                    else if (since_encoder > encoder_timeout && encoder_bad < ENC_DEBOUNCE)
                    begin
                        encoder_bad += 2'd1;
                        if (encoder_bad == ENC_DEBOUNCE)
                        begin
                            active |= F_ENC_STALE | F_ENC_INVALID;
                            latched |= F_ENC_INVALID;
                            events[EV_ENC] += 1;
                            enter_safe(c.now_ms);
                        end
                    end
                CMD_CURRENT:
                begin
                    left_over = check_channel(c.left_current, left_over, F_OC_LEFT, c.now_ms);
                    right_over = check_channel(c.right_current, right_over, F_OC_RIGHT,
                                               c.now_ms);
                end
                CMD_POWER:
                    if (c.supply_voltage < supply_limit)
                    begin
                        if (supply_low < PWR_DEBOUNCE)
                            supply_low += 3'd1;
                        if (supply_low == PWR_DEBOUNCE)
                        begin
                            active |= F_POWER_LOW;
                            latched |= F_POWER_LOW;
                            events[EV_POWER] += 1;
                            enter_safe(c.now_ms);
                        end
                    end
                    else
                    begin
                        supply_low = '0;
                        if (!in_safe)
                            active &= ~F_POWER_LOW;
                    end
                CMD_RECOVER:
                    if (in_safe && active == '0 && since_entry > recovery_delay)
                    begin
                        in_safe = 1'b0;
                        events[EV_RECOV] += 1;
                        encoder_seen = c.now_ms;
                    end
                CMD_CLEAR:
                begin
                    active = '0;
                    latched = '0;
                    encoder_bad = '0;
                    left_over = '0;
                    right_over = '0;
                    supply_low = '0;
                    in_safe = 1'b0;
                end
                default: ;
            endcase
            s.fault_flags = active;
            s.latched_flags = latched;
            s.safe_active = in_safe;
            s.safe_entries = events[EV_SAFE];
            s.encoder_timeout_count = events[EV_ENC];
            s.overcurrent_count = events[EV_OC];
            s.power_low_count = events[EV_POWER];
            s.recovery_count = events[EV_RECOV];
            s.kick_count = events[EV_KICK];
            expected_status.push_back(s);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_status(status_t s);
            status_t want;
            if (expected_status.size() == 0)
            begin
                $error("status transaction arrived with no command outstanding");
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("fault_flags", 32'(want.fault_flags), 32'(s.fault_flags));
            compare_field("latched_flags", 32'(want.latched_flags), 32'(s.latched_flags));
            compare_field("safe_active", 32'(want.safe_active), 32'(s.safe_active));
            compare_field("safe_entries", want.safe_entries, s.safe_entries);
            compare_field("encoder_timeout_count", want.encoder_timeout_count,
                          s.encoder_timeout_count);
            compare_field("overcurrent_count", want.overcurrent_count, s.overcurrent_count);
            compare_field("power_low_count", want.power_low_count, s.power_low_count);
            compare_field("recovery_count", want.recovery_count, s.recovery_count);
            compare_field("kick_count", want.kick_count, s.kick_count);
        endfunction
    endclass

    safety_status_model status_model = new();
    bit [31:0]          clock_ms = '0;
    bit                 steady = 1'b0;
    int unsigned        cycles = 0;

    fault_monitor_safe_state u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status       (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit take_break();
        return !steady && $urandom_range(99) < IDLE_PERCENT;
    endfunction

    function automatic cmd_t pack_cmd(logic [2:0] op, bit valid, bit [31:0] now,
                                      bit [11:0] right, bit [11:0] left, bit [15:0] supply);
        cmd_t c;
        c.command = op;
        c.encoder_valid = valid;
        c.now_ms = now;
        c.right_current = right;
        c.left_current = left;
        c.supply_voltage = supply;
        return c;
    endfunction

    function automatic logic [2:0] pick_check();
        case ($urandom_range(2))
            0: return CMD_ENCODER;
            1: return CMD_CURRENT;
            default: return CMD_POWER;
        endcase
    endfunction

    // Builds a command with random content; bad asks for a reading that counts
    // toward a fault under the current limits.
    function automatic cmd_t random_cmd(logic [2:0] op, bit bad);
        cmd_t      c;
        bit [11:0] lim;
        bit [15:0] slim;
        lim = status_model.current_limit;
        slim = status_model.supply_limit;
        if ($urandom_range(19) == 0)
            clock_ms += $urandom;
        else
            clock_ms += $urandom_range(150);
        c = pack_cmd(op, 1'($urandom), clock_ms, 12'($urandom), 12'($urandom),
                     16'($urandom));
        case (op)
            CMD_ENCODER: c.encoder_valid = !bad;
            CMD_CURRENT:
                if (bad && lim != 12'hFFF)
                begin
                    if ($urandom_range(4) != 0)
                        c.left_current = 12'(lim + 1 + $urandom_range(4094 - lim));
                    if ($urandom_range(4) != 0)
                        c.right_current = 12'(lim + 1 + $urandom_range(4094 - lim));
                end
                else if (!bad)
                begin
                    c.left_current = 12'($urandom_range(lim));
                    c.right_current = 12'($urandom_range(lim));
                end
            CMD_POWER:
                if (bad && slim != 16'h0)
                    c.supply_voltage = 16'($urandom_range(slim - 1));
                else if (!bad)
                    c.supply_voltage = 16'(slim + $urandom_range(65535 - slim));
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_cmd(cmd_t c);
        if (take_break())
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while (take_break())
                @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        status_model.note_command(c);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        status_model.set_limit(index, value);
        @(posedge clk);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (status_model.expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (status_valid && !status_stall)
                status_model.check_status(status);
            status_stall <= take_break();
        end
    end

    initial
    begin
        int         sent;
        int         pick;
        int         len;
        logic [2:0] op;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encoder debounce, including a reading that is invalid but not yet stale.
        send_cmd(pack_cmd(CMD_TICK, 1'b0, 32'd10, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_ENCODER, 1'b1, 32'd50, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_ENCODER, 1'b0, 32'd100, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_ENCODER, 1'b0, 32'd200, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_ENCODER, 1'b0, 32'd300, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_ENCODER, 1'b0, 32'd400, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_ENCODER, 1'b1, 32'd450, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_RECOVER, 1'b0, 32'd2000, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_CLEAR, 1'b0, 32'd2010, 12'd0, 12'd0, 16'd0));
        // Overcurrent on the left channel, then readings exactly at the limit.
        for (int i = 0; i < 3; i++)
            send_cmd(pack_cmd(CMD_CURRENT, 1'b0, 32'd2020 + i, 12'd0, 12'hFFF, 16'd0));
        send_cmd(pack_cmd(CMD_CURRENT, 1'b0, 32'd2050, 12'd3000, 12'd3000, 16'd0));
        send_cmd(pack_cmd(CMD_CLEAR, 1'b0, 32'd2060, 12'd0, 12'd0, 16'd0));
        for (int i = 0; i < 3; i++)
            send_cmd(pack_cmd(CMD_CURRENT, 1'b1, 32'd2070 + i, 12'hFFF, 12'd3001, 16'd0));
        // Supply low while already in safe state, past the saturation point.
        for (int i = 0; i < 5; i++)
            send_cmd(pack_cmd(CMD_POWER, 1'b0, 32'd2100 + i, 12'd0, 12'd0, 16'd9999));
        send_cmd(pack_cmd(CMD_POWER, 1'b0, 32'd2110, 12'd0, 12'd0, 16'hFFFF));
        send_cmd(pack_cmd(CMD_CLEAR, 1'b0, 32'd2120, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_POWER, 1'b0, 32'd2130, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_POWER, 1'b0, 32'd2140, 12'd0, 12'd0, 16'd10000));
        send_cmd(pack_cmd(CMD_RECOVER, 1'b0, 32'd9000, 12'd0, 12'd0, 16'd0));
        // Elapsed time across the 32-bit wrap.
        send_cmd(pack_cmd(CMD_ENCODER, 1'b1, 32'hFFFF_FFF0, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_ENCODER, 1'b0, 32'h0000_0060, 12'd0, 12'd0, 16'd0));
        send_cmd(pack_cmd(CMD_RSVD_6, 1'b1, 32'h0000_0070, 12'hFFF, 12'hFFF, 16'd0));
        send_cmd(pack_cmd(CMD_RSVD_7, 1'b0, 32'h0000_0080, 12'd0, 12'd0, 16'hFFFF));
        clock_ms = 32'h0000_0100;

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_reg(REG_ENC_TIMEOUT, ENC_TIMEOUT_RST);
                    write_reg(REG_OC_LIMIT, 32'(OC_LIMIT_RST));
                    write_reg(REG_PWR_LIMIT, 32'(PWR_LIMIT_RST));
                    write_reg(REG_REC_DELAY, REC_DELAY_RST);
                end
                1:
                begin
                    write_reg(REG_ENC_TIMEOUT, 32'd0);
                    write_reg(REG_OC_LIMIT, 32'd0);
                    write_reg(REG_PWR_LIMIT, 32'd0);
                    write_reg(REG_REC_DELAY, 32'd0);
                end
                2:
                begin
                    write_reg(REG_ENC_TIMEOUT, 32'hFFFF_FFFF);
                    write_reg(REG_OC_LIMIT, 32'h0000_0FFF);
                    write_reg(REG_PWR_LIMIT, 32'h0000_FFFF);
                    write_reg(REG_REC_DELAY, 32'hFFFF_FFFF);
                end
                default:
                begin
                    write_reg(REG_ENC_TIMEOUT, $urandom_range(300));
                    write_reg(REG_OC_LIMIT, $urandom_range(4000, 500));
                    write_reg(REG_PWR_LIMIT, $urandom_range(60000, 2000));
                    write_reg(REG_REC_DELAY, $urandom_range(2000));
                end
            endcase
            steady = (p == 2);
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    op = pick_check();
                    len = $urandom_range(6, 1);
                    repeat (len)
                    begin
                        send_cmd(random_cmd(op, $urandom_range(9) != 0));
                        sent++;
                        if ($urandom_range(4) == 0)
                        begin
                            send_cmd(random_cmd(CMD_TICK, 1'b0));
                            sent++;
                        end
                    end
                end
                else
                begin
                    if (pick < 50)
                        send_cmd(random_cmd(CMD_CLEAR, 1'b0));
                    else if (pick < 60)
                        send_cmd(random_cmd(CMD_RECOVER, 1'b0));
                    else if (pick < 75)
                        send_cmd(random_cmd(pick_check(), 1'b0));
                    else if (pick < 85)
                        send_cmd(random_cmd(CMD_TICK, 1'b0));
                    else
                        send_cmd(random_cmd(3'($urandom_range(7)), 1'($urandom_range(1))));
                    sent++;
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (status_model.mismatches == 0 && status_model.expected_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== fault_monitor_safe_state.f =====
rtl/fms_pkg.sv
rtl/fms_cfg_regs.sv
rtl/fms_engine.sv
rtl/fault_monitor_safe_state.sv
tb/tb.sv
